// ----- rtl/mt_pkg.sv -----
// Package for the MT19937 generator: table geometry, opcodes and the
// constants and functions of the twist and tempering steps.
// No dependencies.
`timescale 1ns / 1ps

package mt_pkg;

  localparam int unsigned TableDepth = 624;
  localparam int unsigned TwistOffset = 397;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  localparam logic [31:0] INIT_MULT = 32'h6c07_8965;
  localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [31:0] LOWER_MASK = 32'h7fff_ffff;
  localparam logic [31:0] MATRIX_A = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C = 32'hefc6_0000;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;

  // One step of the seeding recurrence, without the index term.
  function automatic logic [31:0] seed_mix(input logic [31:0] prev);
    logic [31:0] x;
    x = prev ^ (prev >> 30);
    return 32'(INIT_MULT * x);
  endfunction

  // New table word from the current, the following and the far word.
  function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] w;
    y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    w = far ^ (y >> 1);
    if (y[0]) begin
      w = w ^ MATRIX_A;
    end
    return w;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ----- rtl/mersenne_twister_generator.sv -----
// MT19937 generator top level: state table memory, seeding and twist
// sequencer, tempering and the output register.
// Depends on mt_pkg.
//
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+-----------------------
// in      | input     | in_valid_i / in_ready_o    | opcode_i, seed_i
// out     | output    | out_valid_o / out_ready_i  | number_o
//
// A draw reads the table, then tempers the word into the output
// register. A draw at position zero first regenerates the table, one word
// a cycle through the dual-read-port memory.
// A reseed fills the table one word a cycle (one multiplier in the
// loop), then delivers its zero result. After reset the same fill runs
// with seed 5489 while in_ready_o is low.
// A full output register stalls the block in its last cycle of work.
`timescale 1ns / 1ps

module mersenne_twister_generator #(
  parameter int unsigned TableDepth = mt_pkg::TableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] number_o
);

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam logic [IdxW-1:0] Last = IdxW'(TableDepth - 1);
  localparam logic [IdxW:0] Depth = (IdxW + 1)'(TableDepth);
  localparam logic [IdxW:0] NxtStep = (IdxW + 1)'(2);
  localparam logic [IdxW:0] FarStep = (IdxW + 1)'(mt_pkg::TwistOffset + 1);

  localparam logic [2:0] S_FILL    = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_TWPRIME = 3'd2;
  localparam logic [2:0] S_TWLOAD  = 3'd3;
  localparam logic [2:0] S_TWIST   = 3'd4;
  localparam logic [2:0] S_DATA    = 3'd5;
  localparam logic [2:0] S_RESULT  = 3'd6;

  logic [31:0] table_mem [TableDepth];
  logic [31:0] rd_a_q, rd_b_q;
  logic        rd_a_en, rd_b_en;
  logic [IdxW-1:0] rd_a_addr, rd_b_addr;
  logic        mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [31:0] mem_wdata;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [31:0]     val_q, val_d;
  logic [31:0]     cur_q, cur_d;
  logic            report_q, report_d;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     number_q, number_d;

  logic            out_free;
  logic            in_accept;
  logic [IdxW:0]   a_sum, b_sum;
  logic [IdxW-1:0] a_next, b_next;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_a_en) begin
      rd_a_q <= table_mem[rd_a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_b_en) begin
      rd_b_q <= table_mem[rd_b_addr];
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign number_o = number_q;

  // Read addresses for the following twist step, both taken modulo the depth.
  assign a_sum = {1'b0, idx_q} + NxtStep;
  assign b_sum = {1'b0, idx_q} + FarStep;
  assign a_next = (a_sum >= Depth) ? IdxW'(a_sum - Depth) : a_sum[IdxW-1:0];
  assign b_next = (b_sum >= Depth) ? IdxW'(b_sum - Depth) : b_sum[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    pos_d = pos_q;
    val_d = val_q;
    cur_d = cur_q;
    report_d = report_q;
    out_valid_d = out_valid_q && !out_ready_i;
    number_d = number_q;
    rd_a_en = 1'b0;
    rd_b_en = 1'b0;
    rd_a_addr = '0;
    rd_b_addr = '0;
    mem_we = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = val_q;

    case (state_q)
      S_FILL: begin
        mem_we = 1'b1;
        val_d = mt_pkg::seed_mix(val_q) + 32'(idx_q) + 32'd1;
        if (idx_q == Last) begin
          pos_d = '0;
          state_d = report_q ? S_RESULT : S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (opcode_i == mt_pkg::OP_DRAW) begin
            if (pos_q == '0) begin
              state_d = S_TWPRIME;
            end else begin
              rd_a_en = 1'b1;
              rd_a_addr = pos_q;
              state_d = S_DATA;
            end
          end else begin
            val_d = seed_i;
            idx_d = '0;
            report_d = 1'b1;
            state_d = S_FILL;
          end
        end
      end
      S_TWPRIME: begin
        rd_a_en = 1'b1;
        rd_a_addr = '0;
        state_d = S_TWLOAD;
      end
      S_TWLOAD: begin
        // Word zero arrives; issue the reads for the first step.
        cur_d = rd_a_q;
        rd_a_en = 1'b1;
        rd_b_en = 1'b1;
        rd_a_addr = IdxW'(1);
        rd_b_addr = IdxW'(mt_pkg::TwistOffset);
        idx_d = '0;
        state_d = S_TWIST;
      end
      S_TWIST: begin
        // The following word read here is still the original one, except at
        // the last step, where entry zero already holds its new value as the
        // in-place update requires.
        mem_we = 1'b1;
        mem_wdata = mt_pkg::twist_word(cur_q, rd_a_q, rd_b_q);
        cur_d = rd_a_q;
        rd_a_en = 1'b1;
        if (idx_q == Last) begin
          rd_a_addr = '0;
          state_d = S_DATA;
        end else begin
          rd_b_en = 1'b1;
          rd_a_addr = a_next;
          rd_b_addr = b_next;
          idx_d = idx_q + 1'b1;
        end
      end
      S_DATA: begin
        if (out_free) begin
          number_d = mt_pkg::temper(rd_a_q);
          out_valid_d = 1'b1;
          pos_d = (pos_q == Last) ? '0 : pos_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          number_d = '0;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL;
      idx_q <= '0;
      pos_q <= '0;
      val_q <= mt_pkg::DEFAULT_SEED;
      report_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      pos_q <= pos_d;
      val_q <= val_d;
      report_q <= report_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    number_q <= number_d;
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= Last)
    else $error("position left the table range");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr <= Last))
    else $error("table write beyond the last entry");

  a_reseed_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && opcode_i == mt_pkg::OP_RESEED)
      |=> (state_q == S_FILL && idx_q == '0 && report_q))
    else $error("reseed did not start the fill at entry zero");

  a_twist_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TWIST && idx_q == Last) |=> (state_q == S_DATA && pos_q == '0))
    else $error("table regeneration did not end in a read of word zero");

  a_draw_twist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && opcode_i == mt_pkg::OP_DRAW && pos_q == '0) |=> (state_q == S_TWPRIME))
    else $error("draw at position zero skipped regeneration");
`endif

endmodule

// ----- bench/mersenne_twister_generator_tb.sv -----
// Self-checking testbench for the MT19937 generator: directed and random
// draws and reseeds, checked against a predictor kept inside the bench.
// Depends on mt_pkg and mersenne_twister_generator.
`timescale 1ns / 1ps

module mersenne_twister_generator_tb;

  localparam int unsigned TABLE_DEPTH = 624;
  localparam int unsigned FAR_OFFSET = 397;
  localparam logic [31:0] SEED_MULT = 32'h6c07_8965;
  localparam logic [31:0] MSB_MASK = 32'h8000_0000;
  localparam logic [31:0] LSBS_MASK = 32'h7fff_ffff;
  localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_MASK_C = 32'hefc6_0000;
  localparam logic [31:0] POWER_ON_SEED = 32'd5489;
  localparam int unsigned RANDOM_DRAW_RUN = 700;
  localparam int unsigned RANDOM_MIXED = 750;
  localparam int unsigned FLUSH_CYCLES = 700;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic        opcode;
    logic [31:0] seed;
  } gen_request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        opcode_i = mt_pkg::OP_DRAW;
  logic [31:0] seed_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] number_o;

  // Predictor state: the twister table and the read position.
  logic [31:0]  mt_state [TABLE_DEPTH];
  int unsigned  mt_index;

  gen_request_t pending_requests[$];
  logic [31:0]  expected_numbers[$];

  int unsigned  total_requests;
  int unsigned  accepted_count;
  int unsigned  checked_count;
  int unsigned  error_count;
  int unsigned  draw_count;
  int unsigned  reseed_count;
  int unsigned  regen_count;
  longint unsigned cycle_count;
  int unsigned  hold_left;
  bit           hold_done;
  bit           offer;
  logic [31:0]  wanted;

  mersenne_twister_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .seed_i      (seed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .number_o    (number_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void load_seed(input logic [31:0] s);
    logic [31:0] p;
    mt_state[0] = s;
    for (int unsigned i = 1; i < TABLE_DEPTH; i++) begin
      p = mt_state[i - 1];
      mt_state[i] = 32'(SEED_MULT * (p ^ (p >> 30))) + 32'(i);
    end
    mt_index = 0;
  endfunction

  function automatic void regenerate_table();
    logic [31:0] y;
    logic [31:0] w;
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      y = (mt_state[i] & MSB_MASK) | (mt_state[(i + 1) % TABLE_DEPTH] & LSBS_MASK);
      w = mt_state[(i + FAR_OFFSET) % TABLE_DEPTH] ^ (y >> 1);
      if (y[0]) begin
        w = w ^ TWIST_XOR;
      end
      mt_state[i] = w;
    end
  endfunction

  function automatic logic [31:0] temper_word(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & TEMPER_MASK_B);
    t = t ^ ((t << 15) & TEMPER_MASK_C);
    return t ^ (t >> 18);
  endfunction

  // Number the block should return for one accepted request.
  function automatic logic [31:0] predict_number(input gen_request_t req);
    logic [31:0] word;
    if (req.opcode == mt_pkg::OP_RESEED) begin
      load_seed(req.seed);
      reseed_count++;
      return '0;
    end
    if (mt_index >= TABLE_DEPTH) begin
      mt_index = 0;
    end
    if (mt_index == 0) begin
      regenerate_table();
      regen_count++;
    end
    word = temper_word(mt_state[mt_index]);
    mt_index = (mt_index + 1) % TABLE_DEPTH;
    draw_count++;
    return word;
  endfunction

  function automatic void add_request(input logic op, input logic [31:0] s);
    gen_request_t req;
    req.opcode = op;
    req.seed = s;
    pending_requests.push_back(req);
  endfunction

  // Idling phases follow the share of transactions already accepted.
  function automatic int unsigned sender_idle_pct();
    if (accepted_count < total_requests / 3) begin
      return 30;
    end else if (accepted_count < 2 * total_requests / 3) begin
      return 88;
    end
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (accepted_count < total_requests / 3) begin
      return 88;
    end else if (accepted_count < 2 * total_requests / 3) begin
      return 30;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Request driver: the payload holds until the transaction completes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_numbers.push_back(predict_number(pending_requests.pop_front()));
        accepted_count++;
      end
      if (!in_valid_i || in_ready_o) begin
        offer = (pending_requests.size() != 0) && ($urandom_range(99) >= sender_idle_pct());
        in_valid_i <= offer;
        if (offer) begin
          opcode_i <= pending_requests[0].opcode;
          seed_i <= pending_requests[0].seed;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_numbers.size() == 0) begin
          $error("number: expected nothing, actual 0x%08h", number_o);
          error_count++;
        end else begin
          wanted = expected_numbers.pop_front();
          checked_count++;
          if (number_o !== wanted) begin
            $error("number: expected 0x%08h, actual 0x%08h", wanted, number_o);
            error_count++;
          end
        end
      end
      // Once the sender stops idling, block the output for a long stretch so
      // that the generator backs up and stalls its input.
      if (!hold_done && accepted_count >= 2 * total_requests / 3) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  initial begin
    load_seed(POWER_ON_SEED);

    // Directed part: power-on table, ignored seed bits, extreme seeds,
    // back-to-back reseeds and a reseed straight into a draw.
    add_request(mt_pkg::OP_DRAW, 32'h0000_0000);
    add_request(mt_pkg::OP_DRAW, 32'hffff_ffff);
    add_request(mt_pkg::OP_DRAW, 32'h5555_5555);
    add_request(mt_pkg::OP_RESEED, 32'h0000_0000);
    add_request(mt_pkg::OP_DRAW, 32'haaaa_aaaa);
    add_request(mt_pkg::OP_DRAW, 32'h0000_0000);
    add_request(mt_pkg::OP_RESEED, 32'hffff_ffff);
    add_request(mt_pkg::OP_DRAW, 32'hffff_ffff);
    add_request(mt_pkg::OP_DRAW, 32'h0000_0000);
    add_request(mt_pkg::OP_RESEED, 32'h8000_0000);
    add_request(mt_pkg::OP_DRAW, 32'h0000_0000);
    add_request(mt_pkg::OP_RESEED, 32'h0000_0001);
    add_request(mt_pkg::OP_DRAW, 32'h0000_0000);
    add_request(mt_pkg::OP_RESEED, 32'hdead_beef);
    add_request(mt_pkg::OP_RESEED, POWER_ON_SEED);
    add_request(mt_pkg::OP_DRAW, 32'h0000_0000);
    add_request(mt_pkg::OP_DRAW, 32'h7fff_ffff);
    add_request(mt_pkg::OP_DRAW, 32'h8000_0000);
    add_request(mt_pkg::OP_RESEED, 32'h1234_5678);
    add_request(mt_pkg::OP_DRAW, 32'hffff_ffff);

    // A long run of draws wraps the position and forces a regeneration.
    for (int unsigned i = 0; i < RANDOM_DRAW_RUN; i++) begin
      add_request(mt_pkg::OP_DRAW, $urandom());
    end
    for (int unsigned i = 0; i < RANDOM_MIXED; i++) begin
      if ($urandom_range(39) == 0) begin
        add_request(mt_pkg::OP_RESEED, $urandom());
      end else begin
        add_request(mt_pkg::OP_DRAW, $urandom());
      end
    end
    total_requests = pending_requests.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (expected_numbers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (FLUSH_CYCLES) @(posedge clk_i);

    if (expected_numbers.size() != 0) begin
      $error("number: %0d results never arrived", expected_numbers.size());
      error_count++;
    end
    $display("Covered %0d draws and %0d reseeds, %0d full table regenerations.",
             draw_count, reseed_count, regen_count);
    $display("%0d results checked under three idling mixes and one long output hold.",
             checked_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mt_pkg.sv
rtl/mersenne_twister_generator.sv
bench/mersenne_twister_generator_tb.sv
